// ===== rtl/grsd_pkg.sv =====
// shared types and constants for the golomb-rice set decoder
package grsd_pkg;

    localparam int VALUE_W     = 64;   // running value and quotient width
    localparam int REM_W       = 32;   // remainder accumulator width
    localparam int RICE_W      = 6;    // rice parameter register width
    localparam int COUNT_W     = 32;   // element count width
    localparam int BYTE_W      = 8;    // encoded byte width
    localparam int POS_W       = 4;    // bit position within a byte, 0..8
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [RICE_W-1:0]     MAX_RICE   = 6'd32;
    localparam logic [RICE_W-1:0]     RICE_RESET = 6'd19;
    localparam logic [POS_W-1:0]      BYTE_BITS  = 4'd8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RICE_BITS     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_ELEMENT_COUNT = 1'b1;

    // one queued input word
    typedef struct packed {
        logic [BYTE_W-1:0] encoded_byte;
        logic              first_byte;
        logic              final_byte;
    } grsd_word_t;

    // one finished element (or truncation mark) from the scanner
    typedef struct packed {
        logic [VALUE_W-1:0] quotient;
        logic [REM_W-1:0]   remainder;
        logic               restart;    // first element since a clear
        logic               last;
        logic               truncated;
    } grsd_rec_t;

endpackage

// ===== rtl/grsd_queue.sv =====
// short fifo between the input port and the bit scanner
module grsd_queue
    import grsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  grsd_word_t push_word,
    output logic       full,
    output logic       head_valid,
    output grsd_word_t head_word,
    input  logic       pop
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    grsd_word_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");
`endif

endmodule

// ===== rtl/grsd_scan.sv =====
// bit scanner: walks the head byte, finishes at most one element per cycle
module grsd_scan
    import grsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [RICE_W-1:0]  eff_bits,
    input  logic [COUNT_W-1:0] element_count,
    input  logic               head_valid,
    input  grsd_word_t         head_word,
    output logic               pop,
    output logic               rec_valid,
    output grsd_rec_t          rec,
    input  logic               rec_ready
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0] q_reg, q_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [RICE_W-1:0]  taken_reg, taken_next;
    logic               in_rem_reg, in_rem_next;
    logic [COUNT_W-1:0] done_reg, done_next;
    logic               fin_reg, fin_next;

    // start-of-cycle state, cleared when a first byte is picked up
    logic [VALUE_W-1:0] st_q;
    logic [REM_W-1:0]   st_rem;
    logic [RICE_W-1:0]  st_taken;
    logic               st_in_rem;
    logic [COUNT_W-1:0] st_done;
    logic               st_fin;

    logic                  done_hit;
    logic [POS_W-1:0]      nleft, ones, used_u, avail, take_k, pos_new;
    logic [BYTE_W-1:0]     win, win2;
    logic                  entering, in_rem_after, complete, elem_last, emit, adv;
    logic [RICE_W-1:0]     taken_base, need, taken_new;
    logic [REM_W+BYTE_W-1:0] rem_cat;
    logic [REM_W-1:0]      rem_new;
    logic [VALUE_W-1:0]    q_fin;
    logic [COUNT_W-1:0]    done_inc;
    logic                  pop_c, found_zero;
    logic [POS_W-1:0]      pos_c;

    always_comb begin
        if (pos_reg == '0 && head_word.first_byte) begin
            st_q      = '0;
            st_rem    = '0;
            st_taken  = '0;
            st_in_rem = 1'b0;
            st_done   = '0;
            st_fin    = 1'b0;
        end else begin
            st_q      = q_reg;
            st_rem    = rem_reg;
            st_taken  = taken_reg;
            st_in_rem = in_rem_reg;
            st_done   = done_reg;
            st_fin    = fin_reg;
        end

        done_hit = st_fin || (st_done >= element_count);
        nleft    = BYTE_BITS - pos_reg;
        win      = BYTE_W'(head_word.encoded_byte << pos_reg);

        // leading ones of the remaining bits; consumed bits shift in as zeros
        ones       = '0;
        found_zero = 1'b0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (!found_zero && win[i]) begin
                ones = ones + 1'b1;
            end else begin
                found_zero = 1'b1;
            end
        end

        if (!st_in_rem) begin
            entering = (ones < nleft);
            used_u   = entering ? ones + 1'b1 : ones;
            q_fin    = st_q + VALUE_W'(ones);
        end else begin
            entering = 1'b0;
            used_u   = '0;
            q_fin    = st_q;
        end

        in_rem_after = st_in_rem || entering;
        taken_base   = entering ? '0 : st_taken;
        avail        = nleft - used_u;

        // rice_bits lowered mid-element still costs one more remainder bit
        if (entering) begin
            need = eff_bits;
        end else if (st_taken >= eff_bits) begin
            need = 6'd1;
        end else begin
            need = eff_bits - st_taken;
        end

        if (!in_rem_after) begin
            take_k = '0;
        end else if (RICE_W'(avail) < need) begin
            take_k = avail;
        end else begin
            take_k = POS_W'(need);
        end

        win2      = BYTE_W'(win << used_u);
        rem_cat   = {st_rem, win2} >> (BYTE_BITS - take_k);
        rem_new   = rem_cat[REM_W-1:0];
        taken_new = taken_base + RICE_W'(take_k);
        complete  = in_rem_after && (taken_new >= eff_bits) && (entering || take_k != '0);
        pos_new   = pos_reg + used_u + take_k;
        done_inc  = st_done + 1'b1;
        elem_last = (done_inc >= element_count);

        // candidate next state
        q_next      = st_q;
        rem_next    = st_rem;
        taken_next  = st_taken;
        in_rem_next = st_in_rem;
        done_next   = st_done;
        fin_next    = st_fin;
        pop_c       = 1'b1;
        pos_c       = '0;
        emit        = 1'b0;
        rec         = '0;

        if (done_hit) begin
            // padding or bytes after the end
            pop_c = 1'b1;
        end else if (complete) begin
            emit          = 1'b1;
            rec.quotient  = q_fin;
            rec.remainder = rem_new;
            rec.restart   = (st_done == '0);
            rec.last      = elem_last;
            q_next        = '0;
            rem_next      = '0;
            taken_next    = '0;
            in_rem_next   = 1'b0;
            done_next     = done_inc;
            fin_next      = elem_last;
            if (elem_last || (pos_new == BYTE_BITS && !head_word.final_byte)) begin
                pop_c = 1'b1;
            end else begin
                // more bits, or a truncation mark still owed on the final byte
                pop_c = 1'b0;
                pos_c = pos_new;
            end
        end else begin
            q_next      = q_fin;
            rem_next    = rem_new;
            taken_next  = taken_new;
            in_rem_next = in_rem_after;
            if (head_word.final_byte) begin
                emit          = 1'b1;
                rec.truncated = 1'b1;
                fin_next      = 1'b1;
            end
        end

        adv = head_valid && (!emit || rec_ready);
        if (!adv) begin
            q_next      = q_reg;
            rem_next    = rem_reg;
            taken_next  = taken_reg;
            in_rem_next = in_rem_reg;
            done_next   = done_reg;
            fin_next    = fin_reg;
            pos_next    = pos_reg;
        end else begin
            pos_next = pos_c;
        end
    end

    assign pop       = adv && pop_c;
    assign rec_valid = head_valid && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            q_reg      <= '0;
            rem_reg    <= '0;
            taken_reg  <= '0;
            in_rem_reg <= 1'b0;
            done_reg   <= '0;
            fin_reg    <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            q_reg      <= q_next;
            rem_reg    <= rem_next;
            taken_reg  <= taken_next;
            in_rem_reg <= in_rem_next;
            done_reg   <= done_next;
            fin_reg    <= fin_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= BYTE_BITS)
        else $error("bit position past end of byte");

    a_trunc_final: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_valid && rec.truncated |-> head_word.final_byte)
        else $error("truncation mark on a non-final byte");

    a_taken_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        taken_reg <= MAX_RICE)
        else $error("remainder bit count out of range");
`endif

endmodule

// ===== rtl/grsd_accum.sv =====
// delta build and running sum, three-stage pipeline with output register
module grsd_accum
    import grsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [RICE_W-1:0]  eff_bits,
    input  logic               rec_valid,
    input  grsd_rec_t          rec,
    output logic               rec_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    // stage 1: raw record
    logic               v1_reg;
    grsd_rec_t          rec1_reg;
    // stage 2: delta
    logic               v2_reg;
    logic [VALUE_W-1:0] delta2_reg;
    logic               restart2_reg, last2_reg, trunc2_reg;
    // stage 3: output
    logic               v3_reg;
    logic [VALUE_W-1:0] value3_reg;
    logic               last3_reg, trunc3_reg;
    logic [VALUE_W-1:0] running_reg, running_next;

    logic r1, r2, r3;

    assign r3        = !v3_reg || m_tready;
    assign r2        = !v2_reg || r3;
    assign r1        = !v1_reg || r2;
    assign rec_ready = r1;

    always_comb begin
        running_next = (restart2_reg ? '0 : running_reg) + delta2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= rec_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && rec_valid) begin
            rec1_reg <= rec;
        end
        if (r2 && v1_reg) begin
            delta2_reg   <= (rec1_reg.quotient << eff_bits) + VALUE_W'(rec1_reg.remainder);
            restart2_reg <= rec1_reg.restart;
            last2_reg    <= rec1_reg.last;
            trunc2_reg   <= rec1_reg.truncated;
        end
        if (r3 && v2_reg) begin
            last3_reg  <= last2_reg;
            trunc3_reg <= trunc2_reg;
            if (trunc2_reg) begin
                value3_reg <= '0;
            end else begin
                value3_reg  <= running_next;
                running_reg <= running_next;
            end
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = value3_reg;
    assign m_tlast  = last3_reg;
    assign m_tuser  = trunc3_reg;

`ifndef SYNTHESIS
    a_trunc_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
        else $error("truncation word carries a value or last flag");
`endif

endmodule

// ===== rtl/golomb_rice_set_decoder_unit.sv =====
// golomb-rice coded set decoder, top level
//
//  channel   dir  handshake                tdata / tuser / tlast
//  s_        in   s_tvalid / s_tready      encoded_byte / first_byte / final_byte
//  m_        out  m_tvalid / m_tready      element_value / truncated / last_element
//  cfg_      in   cfg_wr_en (no stall)     index 0 rice_bits, 1 element_count
//
//  the scanner holds a byte while elements end before its last bit (other than
//  the set's last), and for the truncation word when a final byte ends exactly
//  on an element and still leaves the set short
//  a result word passes the queue, the scanner and the raw record, delta and output registers
//  m_ backpressure stalls the accumulator stages and the scanner; s_tready drops once the queue is full
//  synchronous active-low aresetn clears queue and pipeline, rice_bits 19, count 0
module golomb_rice_set_decoder_unit
    import grsd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,      // [7:0] encoded_byte
    input  logic [0:0]            s_tuser,      // [0] first_byte
    input  logic                  s_tlast,      // final_byte
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VALUE_W-1:0]    m_tdata,      // [63:0] element_value
    output logic [0:0]            m_tuser,      // [0] truncated
    output logic                  m_tlast,      // last_element
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic [RICE_W-1:0]  rice_bits_reg;
    logic [COUNT_W-1:0] element_count_reg;
    logic [RICE_W-1:0]  eff_bits;

    logic       q_full, head_valid, pop;
    grsd_word_t in_word, head_word;
    logic       rec_valid, rec_ready;
    grsd_rec_t  rec;

    // register file, write only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rice_bits_reg     <= RICE_RESET;
            element_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RICE_BITS:     rice_bits_reg     <= cfg_wr_data[RICE_W-1:0];
                REG_ELEMENT_COUNT: element_count_reg <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // rice parameters above 32 behave as 32
    assign eff_bits = (rice_bits_reg > MAX_RICE) ? MAX_RICE : rice_bits_reg;

    // front: accept words into the queue
    assign s_tready             = !q_full;
    assign in_word.encoded_byte = s_tdata;
    assign in_word.first_byte   = s_tuser[0];
    assign in_word.final_byte   = s_tlast;

    grsd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid),
        .push_word  (in_word),
        .full       (q_full),
        .head_valid (head_valid),
        .head_word  (head_word),
        .pop        (pop)
    );

    // back: bit scanner, at most one element boundary per cycle, held while the accumulator is not ready
    grsd_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .eff_bits      (eff_bits),
        .element_count (element_count_reg),
        .head_valid    (head_valid),
        .head_word     (head_word),
        .pop           (pop),
        .rec_valid     (rec_valid),
        .rec           (rec),
        .rec_ready     (rec_ready)
    );

    // back: delta and running sum, output register
    grsd_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eff_bits  (eff_bits),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser[0])
    );

`ifndef SYNTHESIS
    a_rice_range: assert property (@(posedge aclk) disable iff (!aresetn)
        eff_bits <= MAX_RICE)
        else $error("effective rice parameter out of range");
`endif

endmodule
